// File: hw/rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W         = $clog2(CELL_COUNT);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [BYTE_W-1:0] TERMINATOR_CODE = 8'd0;
    localparam logic [BYTE_W-1:0] BLANK_CHAR      = 8'd32;
    localparam logic [BYTE_W-1:0] BLANK_ATTR      = 8'd7;

    localparam logic [ROW_W-1:0] RESET_ROW = 5'd4;

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BLANK_FIRST = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);

    typedef enum logic {
        MODE_PUT  = 1'b0,
        MODE_READ = 1'b1
    } tcw_mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_RESULT
    } tcw_state_t;

    typedef enum logic [1:0] {
        WK_PUT,
        WK_COPY,
        WK_BLANK
    } tcw_wr_kind_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } tcw_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_attr;
    } tcw_rsp_t;

    typedef struct packed {
        logic              en;
        logic              attr_en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] chr;
        logic [BYTE_W-1:0] attr;
    } tcw_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } tcw_rd_t;

endpackage
`default_nettype wire

// File: hw/rtl/tcw_if.sv
`default_nettype none
interface tcw_req_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [tcw_pkg::BYTE_W-1:0] char_code;
    logic [tcw_pkg::ROW_W-1:0]  read_row;
    logic [tcw_pkg::COL_W-1:0]  read_col;

    modport source (output valid, output mode, output char_code, output read_row,
                    output read_col, input ready);
    modport sink (input valid, input mode, input char_code, input read_row,
                  input read_col, output ready);
endinterface

interface tcw_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic [tcw_pkg::COL_W-1:0]  cursor_col;
    logic                     scrolled;
    logic [tcw_pkg::BYTE_W-1:0] cell_char;
    logic [tcw_pkg::BYTE_W-1:0] cell_attr;

    modport source (output valid, output cursor_row, output cursor_col, output scrolled,
                    output cell_char, output cell_attr, input ready);
    modport sink (input valid, input cursor_row, input cursor_col, input scrolled,
                  input cell_char, input cell_attr, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/text_console_writer_top.sv
// Text console of 25 rows by 80 cells (character byte plus attribute byte) kept in a
// single-port-write screen memory. After reset a clearing pass writes every cell to a
// space of attribute 7, one cell a cycle; no word is taken until the clearing writes
// are done and the last of them has landed in the screen memory.
// A put, newline, ignored zero code or read past the screen edge goes from idle straight to
// the result state, while a read of a cell on the screen passes through a read state first.
// A put or newline that runs past the bottom row scrolls: the scroll engine copies
// rows 1 to 24 up one cell a cycle and then blanks the bottom row. The next word is
// taken while a result still waits on the output side.
`default_nettype none
module text_console_writer_top (
    input wire logic clk,
    input wire logic rst_n,
    tcw_req_if.sink  req,
    tcw_rsp_if.source rsp
);
    import tcw_pkg::*;

    tcw_req_t          req_word;
    tcw_rsp_t          rsp_word;
    tcw_wr_t           mem_wr;
    tcw_rd_t           mem_rd;
    logic [BYTE_W-1:0] mem_char;
    logic [BYTE_W-1:0] mem_attr;
    logic              req_ready;
    logic              rsp_valid;

    assign req_word.mode      = req.mode;
    assign req_word.char_code = req.char_code;
    assign req_word.read_row  = req.read_row;
    assign req_word.read_col  = req.read_col;
    assign req.ready          = req_ready;

    assign rsp.valid      = rsp_valid;
    assign rsp.cursor_row = rsp_word.cursor_row;
    assign rsp.cursor_col = rsp_word.cursor_col;
    assign rsp.scrolled   = rsp_word.scrolled;
    assign rsp.cell_char  = rsp_word.cell_char;
    assign rsp.cell_attr  = rsp_word.cell_attr;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp       (rsp_word),
        .wr        (mem_wr),
        .rd        (mem_rd),
        .rd_char   (mem_char),
        .rd_attr   (mem_attr)
    );

    tcw_screen_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_char (mem_char),
        .rd_attr (mem_attr)
    );

endmodule
`default_nettype wire

// File: hw/rtl/tcw_screen_mem.sv
`default_nettype none
module tcw_screen_mem (
    input  wire logic                        clk,
    input  wire tcw_pkg::tcw_wr_t            wr,
    input  wire tcw_pkg::tcw_rd_t            rd,
    output logic [tcw_pkg::BYTE_W-1:0]       rd_char,
    output logic [tcw_pkg::BYTE_W-1:0]       rd_attr
);
    import tcw_pkg::*;

    // character and attribute bytes kept apart so a put never needs a read
    logic [BYTE_W-1:0] char_mem [CELL_COUNT];
    logic [BYTE_W-1:0] attr_mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            char_mem[wr.addr] <= wr.chr;
            if (wr.attr_en)
            begin
                attr_mem[wr.addr] <= wr.attr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_char <= char_mem[rd.addr];
            rd_attr <= attr_mem[rd.addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire tcw_pkg::tcw_req_t      req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output tcw_pkg::tcw_rsp_t           rsp,
    output tcw_pkg::tcw_wr_t            wr,
    output tcw_pkg::tcw_rd_t            rd,
    input  wire logic [tcw_pkg::BYTE_W-1:0] rd_char,
    input  wire logic [tcw_pkg::BYTE_W-1:0] rd_attr
);
    import tcw_pkg::*;

    tcw_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scrolled_reg, scrolled_next;
    logic [BYTE_W-1:0] cell_char_reg, cell_char_next;
    logic [BYTE_W-1:0] cell_attr_reg, cell_attr_next;

    // registered write slot, lines up copy writes with the registered read data
    logic              wr_pend_reg, wr_pend_next;
    tcw_wr_kind_t      wr_kind_reg, wr_kind_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [BYTE_W-1:0] put_char_reg, put_char_next;

    logic              rsp_valid_reg, rsp_valid_next;
    tcw_rsp_t          rsp_reg, rsp_next;

    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              read_in_range;

    assign row_inc       = {1'b0, row_reg} + 1'b1;
    assign col_inc       = {1'b0, col_reg} + 1'b1;
    assign cursor_addr   = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);
    assign read_addr     = ADDR_W'(req.read_row) * ROW_STRIDE + ADDR_W'(req.read_col);
    assign read_in_range = (32'(req.read_row) < SCREEN_ROWS)
                        && (32'(req.read_col) < SCREEN_COLUMNS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            row_reg       <= RESET_ROW;
            col_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scrolled_reg  <= scrolled_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
        wr_kind_reg   <= wr_kind_next;
        wr_addr_reg   <= wr_addr_next;
        put_char_reg  <= put_char_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        scrolled_next  = scrolled_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        wr_pend_next   = 1'b0;
        wr_kind_next   = wr_kind_reg;
        wr_addr_next   = wr_addr_reg;
        put_char_next  = put_char_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        rd.en          = 1'b0;
        rd.addr        = read_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_pend_next = 1'b1;
                wr_kind_next = WK_BLANK;
                wr_addr_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CELL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // hold off while the last clearing write is still in flight
                req_ready = !wr_pend_reg;
                if (req_valid && !wr_pend_reg)
                begin
                    scrolled_next  = 1'b0;
                    cell_char_next = '0;
                    cell_attr_next = '0;
                    state_next     = ST_RESULT;
                    if (req.mode == MODE_READ)
                    begin
                        if (read_in_range)
                        begin
                            rd.en      = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else if (req.char_code != TERMINATOR_CODE)
                    begin
                        if (req.char_code == NEWLINE_CODE)
                        begin
                            row_next = row_inc[ROW_W-1:0];
                            col_next = '0;
                        end
                        else
                        begin
                            wr_pend_next  = 1'b1;
                            wr_kind_next  = WK_PUT;
                            wr_addr_next  = cursor_addr;
                            put_char_next = req.char_code;
                            if (32'(col_inc) >= SCREEN_COLUMNS)
                            begin
                                row_next = row_inc[ROW_W-1:0];
                                col_next = '0;
                            end
                            else
                            begin
                                col_next = col_inc[COL_W-1:0];
                            end
                        end
                        // only a newline or a wrap can push the cursor off the bottom
                        if ((req.char_code == NEWLINE_CODE || 32'(col_inc) >= SCREEN_COLUMNS)
                            && 32'(row_inc) >= SCREEN_ROWS)
                        begin
                            row_next      = ROW_W'(SCREEN_ROWS - 1);
                            col_next      = '0;
                            scrolled_next = 1'b1;
                            cnt_next      = '0;
                            state_next    = ST_COPY;
                        end
                    end
                end
            end

            ST_READ:
            begin
                cell_char_next = rd_char;
                cell_attr_next = rd_attr;
                state_next     = ST_RESULT;
            end

            ST_COPY:
            begin
                rd.en        = 1'b1;
                rd.addr      = cnt_reg + ROW_STRIDE;
                wr_pend_next = 1'b1;
                wr_kind_next = WK_COPY;
                wr_addr_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == COPY_LAST)
                begin
                    cnt_next   = BLANK_FIRST;
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                wr_pend_next = 1'b1;
                wr_kind_next = WK_BLANK;
                wr_addr_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CELL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cursor_row = row_reg;
                    rsp_next.cursor_col = col_reg;
                    rsp_next.scrolled   = scrolled_reg;
                    rsp_next.cell_char  = cell_char_reg;
                    rsp_next.cell_attr  = cell_attr_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr.en   = wr_pend_reg;
        wr.addr = wr_addr_reg;
        unique case (wr_kind_reg)
            WK_PUT:
            begin
                wr.attr_en = 1'b0;
                wr.chr     = put_char_reg;
                wr.attr    = BLANK_ATTR;
            end
            WK_COPY:
            begin
                wr.attr_en = 1'b1;
                wr.chr     = rd_char;
                wr.attr    = rd_attr;
            end
            default:
            begin
                wr.attr_en = 1'b1;
                wr.chr     = BLANK_CHAR;
                wr.attr    = BLANK_ATTR;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
